[rtl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   // command codes
   typedef enum logic [2:0] {
      OP_CREATE = 3'd0,
      OP_NEXT   = 3'd1,
      OP_SLEEP  = 3'd2,
      OP_BLOCK  = 3'd3,
      OP_WAKE   = 3'd4,
      OP_EXIT   = 3'd5,
      OP_REAP   = 3'd6,
      OP_QUERY  = 3'd7
   } op_type;

   // task states
   typedef enum logic [2:0] {
      TS_FREE     = 3'd0,
      TS_READY    = 3'd1,
      TS_RUNNING  = 3'd2,
      TS_SLEEPING = 3'd3,
      TS_BLOCKED  = 3'd4,
      TS_DEAD     = 3'd5
   } task_state_type;

   // owner actions
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_SET     = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_PASS1 = 2'd1,
      S_PASS2 = 2'd2
   } fsm_type;

   // one task slot as it travels along the ring
   typedef struct packed {
      task_state_type st;
      logic [7:0]     gen;
      logic [31:0]    slices;
      logic [31:0]    wake;
   } slot_type;

   localparam slot_type SLOT_RESET = '{st: TS_FREE, gen: 8'd1, slices: 32'd0, wake: 32'd0};

endpackage

[rtl/rrts_cell.sv]
// ----------------------------------------------------------------------------
// rrts_cell
// One slot of the task ring: holds a slot record and takes its neighbor's
// record on every shift.
// ----------------------------------------------------------------------------
module rrts_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  rrts_pkg::slot_type d,
   output rrts_pkg::slot_type q
);

   rrts_pkg::slot_type slot_ff;

   // slot register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= rrts_pkg::SLOT_RESET;
      end else if (shift) begin
         slot_ff <= d;
      end
   end

   assign q = slot_ff;

endmodule

[rtl/round_robin_task_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task table with generation-checked ids, sleep timers and round robin pick.
// ----------------------------------------------------------------------------
// The slot table is a ring of NUM_SLOTS cells that rotates one place per
// cycle while busy, past a single head unit, so each ring turn visits
// every slot once in slot order. A command is taken when start is high
// and busy is low; create, sleep, block, wake, exit, reap and query take
// one ring turn, next takes two (one turn to wake and pick, one to mark
// the pick running). The result strobe rsp_valid comes in the cycle after
// the last turn, with busy already low, so a new command can be issued in
// that cycle. The receiver must take the result in that cycle; it is not
// held.
module round_robin_task_scheduler #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_task_id,
   input  logic [31:0] req_sleep_ms,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [15:0] rsp_task_id_out,
   output logic [2:0]  rsp_task_state,
   output logic        rsp_id_valid,
   output logic [4:0]  rsp_task_count,
   output logic [31:0] rsp_slice_count,
   output logic [1:0]  rsp_owner_action,
   output logic [4:0]  rsp_owner_id
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IW-1:0] LAST_K = IW'(NUM_SLOTS - 1);

   rrts_pkg::fsm_type  state_ff, state_in;
   rrts_pkg::slot_type ring_q [NUM_SLOTS];
   rrts_pkg::slot_type ring_d [NUM_SLOTS];
   rrts_pkg::slot_type head_in;
   logic               shift;

   // command registers
   rrts_pkg::op_type op_ff;
   logic [15:0] tid_ff;
   logic [31:0] ms_ff, now_ff;

   // scheduler registers
   logic [IW-1:0] step_ff, step_in;
   logic [IW-1:0] last_ff, last_in;
   logic [15:0]   cur_ff, cur_in;

   // pick search
   logic          abv_f_ff, abv_f_in, any_f_ff, any_f_in;
   logic [IW-1:0] abv_k_ff, abv_k_in, any_k_ff, any_k_in;
   logic [7:0]    abv_g_ff, abv_g_in, any_g_ff, any_g_in;

   // result accumulators
   logic        found_ff, found_in;
   logic [15:0] id_ff, id_in;
   logic [2:0]  stout_ff, stout_in;
   logic        valid_ff, valid_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] slc_ff, slc_in;
   logic [1:0]  act_ff, act_in;
   logic [4:0]  own_ff, own_in;
   logic        rsp_ff, rsp_in;

   // ring of slot cells, head at cell zero
   assign shift = (state_ff != rrts_pkg::S_IDLE);

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_ring
      if (i == NUM_SLOTS - 1) begin : g_tail
         assign ring_d[i] = head_in;
      end else begin : g_body
         assign ring_d[i] = ring_q[i+1];
      end
      rrts_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d     (ring_d[i]),
         .q     (ring_q[i])
      );
   end

   // sequencer state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrts_pkg::S_IDLE;
         step_ff  <= '0;
         last_ff  <= LAST_K;
         cur_ff   <= '0;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         last_ff  <= last_in;
         cur_ff   <= cur_in;
         rsp_ff   <= rsp_in;
      end
   end

   // command capture and accumulators
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff  <= rrts_pkg::op_type'(req_op);
         tid_ff <= req_task_id;
         ms_ff  <= req_sleep_ms;
         now_ff <= req_now_ms;
      end
      abv_f_ff <= abv_f_in;
      abv_k_ff <= abv_k_in;
      abv_g_ff <= abv_g_in;
      any_f_ff <= any_f_in;
      any_k_ff <= any_k_in;
      any_g_ff <= any_g_in;
      found_ff <= found_in;
      id_ff    <= id_in;
      stout_ff <= stout_in;
      valid_ff <= valid_in;
      cnt_ff   <= cnt_in;
      slc_ff   <= slc_in;
      act_ff   <= act_in;
      own_ff   <= own_in;
   end

   // head unit and sequencer
   always_comb begin
      rrts_pkg::slot_type hd;
      logic          tgt_live;
      logic          cur_live;
      logic          last_step;
      logic [IW:0]   kp1;
      logic [IW-1:0] sel_k;
      logic [7:0]    sel_g;
      logic          sel_f;
      logic [31:0]   dt;

      hd        = ring_q[0];
      head_in   = hd;
      state_in  = state_ff;
      step_in   = step_ff;
      last_in   = last_ff;
      cur_in    = cur_ff;
      rsp_in    = 1'b0;
      abv_f_in  = abv_f_ff;
      abv_k_in  = abv_k_ff;
      abv_g_in  = abv_g_ff;
      any_f_in  = any_f_ff;
      any_k_in  = any_k_ff;
      any_g_in  = any_g_ff;
      found_in  = found_ff;
      id_in     = id_ff;
      stout_in  = stout_ff;
      valid_in  = valid_ff;
      cnt_in    = cnt_ff;
      slc_in    = slc_ff;
      act_in    = act_ff;
      own_in    = own_ff;

      tgt_live  = (tid_ff[7:0] == 8'(step_ff)) && (tid_ff[15:8] != 8'd0) &&
                  (hd.st != rrts_pkg::TS_FREE) && (hd.gen == tid_ff[15:8]);
      cur_live  = (cur_ff[7:0] == 8'(step_ff)) && (cur_ff[15:8] != 8'd0) &&
                  (hd.st != rrts_pkg::TS_FREE) && (hd.gen == cur_ff[15:8]);
      last_step = (step_ff == LAST_K);
      kp1       = {1'b0, step_ff} + (IW+1)'(1);
      dt        = now_ff - hd.wake;
      sel_f     = abv_f_ff || any_f_ff;
      sel_k     = abv_f_ff ? abv_k_ff : any_k_ff;
      sel_g     = abv_f_ff ? abv_g_ff : any_g_ff;

      case (state_ff)
         rrts_pkg::S_IDLE: begin
            if (start) begin
               state_in = rrts_pkg::S_PASS1;
               step_in  = '0;
               abv_f_in = 1'b0;
               any_f_in = 1'b0;
               found_in = 1'b0;
               id_in    = '0;
               stout_in = '0;
               valid_in = 1'b0;
               cnt_in   = '0;
               slc_in   = '0;
               act_in   = rrts_pkg::ACT_NONE;
               own_in   = '0;
            end
         end

         rrts_pkg::S_PASS1: begin
            if (tgt_live) begin
               valid_in = 1'b1;
            end
            case (op_ff)
               rrts_pkg::OP_CREATE: begin
                  if (!found_ff && hd.st == rrts_pkg::TS_FREE) begin
                     head_in.st     = rrts_pkg::TS_READY;
                     head_in.slices = '0;
                     head_in.wake   = '0;
                     found_in       = 1'b1;
                     id_in          = {hd.gen, 8'(step_ff)};
                  end
               end
               rrts_pkg::OP_NEXT: begin
                  if (hd.st == rrts_pkg::TS_SLEEPING && !dt[31]) begin
                     head_in.st = rrts_pkg::TS_READY;
                  end
                  if (cur_live && hd.st == rrts_pkg::TS_RUNNING) begin
                     head_in.st = rrts_pkg::TS_READY;
                  end
                  if (head_in.st == rrts_pkg::TS_READY) begin
                     if (!any_f_ff) begin
                        any_f_in = 1'b1;
                        any_k_in = step_ff;
                        any_g_in = hd.gen;
                     end
                     if (!abv_f_ff && step_ff > last_ff) begin
                        abv_f_in = 1'b1;
                        abv_k_in = step_ff;
                        abv_g_in = hd.gen;
                     end
                  end
               end
               rrts_pkg::OP_SLEEP: begin
                  if (tgt_live && hd.st != rrts_pkg::TS_DEAD) begin
                     head_in.wake = now_ff + ms_ff;
                     head_in.st   = rrts_pkg::TS_SLEEPING;
                  end
               end
               rrts_pkg::OP_BLOCK: begin
                  if (tgt_live && hd.st != rrts_pkg::TS_DEAD) begin
                     head_in.st = rrts_pkg::TS_BLOCKED;
                  end
               end
               rrts_pkg::OP_WAKE: begin
                  if (tgt_live && (hd.st inside {rrts_pkg::TS_BLOCKED,
                                                 rrts_pkg::TS_SLEEPING})) begin
                     head_in.st = rrts_pkg::TS_READY;
                  end
               end
               rrts_pkg::OP_EXIT: begin
                  if (tgt_live) begin
                     head_in.st = rrts_pkg::TS_DEAD;
                     act_in     = rrts_pkg::ACT_RELEASE;
                     own_in     = 5'(kp1);
                  end
               end
               rrts_pkg::OP_REAP: begin
                  if (hd.st == rrts_pkg::TS_DEAD) begin
                     head_in.st  = rrts_pkg::TS_FREE;
                     head_in.gen = (hd.gen == 8'hFF) ? 8'd1 : hd.gen + 8'd1;
                     cnt_in      = cnt_ff + 5'd1;
                  end
               end
               default: begin
                  if (tgt_live) begin
                     stout_in = hd.st;
                     slc_in   = hd.slices;
                  end
                  if (hd.st != rrts_pkg::TS_FREE) begin
                     cnt_in = cnt_ff + 5'd1;
                  end
               end
            endcase

            step_in = step_ff + IW'(1);
            if (last_step) begin
               step_in = '0;
               case (op_ff)
                  rrts_pkg::OP_NEXT: begin
                     state_in = rrts_pkg::S_PASS2;
                     act_in   = rrts_pkg::ACT_SET;
                     if (abv_f_in || any_f_in) begin
                        id_in  = abv_f_in ? {abv_g_in, 8'(abv_k_in)}
                                          : {any_g_in, 8'(any_k_in)};
                        own_in = abv_f_in ? 5'({1'b0, abv_k_in} + (IW+1)'(1))
                                          : 5'({1'b0, any_k_in} + (IW+1)'(1));
                     end else begin
                        id_in  = '0;
                        own_in = '0;
                     end
                  end
                  rrts_pkg::OP_EXIT: begin
                     state_in = rrts_pkg::S_IDLE;
                     rsp_in   = 1'b1;
                     if (valid_in && tid_ff == cur_ff) begin
                        cur_in = '0;
                     end
                  end
                  rrts_pkg::OP_QUERY: begin
                     state_in = rrts_pkg::S_IDLE;
                     rsp_in   = 1'b1;
                     id_in    = cur_ff;
                  end
                  default: begin
                     state_in = rrts_pkg::S_IDLE;
                     rsp_in   = 1'b1;
                  end
               endcase
            end
         end

         rrts_pkg::S_PASS2: begin
            // mark the chosen slot running
            if (sel_f && step_ff == sel_k) begin
               head_in.st     = rrts_pkg::TS_RUNNING;
               head_in.slices = hd.slices + 32'd1;
            end
            step_in = step_ff + IW'(1);
            if (last_step) begin
               step_in  = '0;
               state_in = rrts_pkg::S_IDLE;
               rsp_in   = 1'b1;
               if (sel_f) begin
                  cur_in  = {sel_g, 8'(sel_k)};
                  last_in = sel_k;
               end else begin
                  cur_in = '0;
               end
            end
         end

         default: begin
            state_in = rrts_pkg::S_IDLE;
         end
      endcase
   end

   // ports
   assign busy             = (state_ff != rrts_pkg::S_IDLE);
   assign rsp_valid        = rsp_ff;
   assign rsp_task_id_out  = id_ff;
   assign rsp_task_state   = stout_ff;
   assign rsp_id_valid     = valid_ff;
   assign rsp_task_count   = cnt_ff;
   assign rsp_slice_count  = slc_ff;
   assign rsp_owner_action = act_ff;
   assign rsp_owner_id     = own_ff;

endmodule

[rtl/rrts_checker.sv]
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks on the scheduler's command and result channels.
// ----------------------------------------------------------------------------
module rrts_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [15:0] rsp_task_id_out,
   input logic [1:0]  rsp_owner_action,
   input logic [4:0]  rsp_owner_id
);

   // a taken command makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command taken but block not busy");

   // a result is a single-cycle pulse
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result appears only as the block goes idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result outside end of command");

   // no owner without an action, and no owner for a failed pick
   a_owner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_owner_action == rrts_pkg::ACT_NONE ||
                     (rsp_owner_action == rrts_pkg::ACT_SET &&
                      rsp_task_id_out == 16'd0)))
      |-> (rsp_owner_id == 5'd0))
      else $error("owner id without matching action");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_task_id_out  (rsp_task_id_out),
   .rsp_owner_action (rsp_owner_action),
   .rsp_owner_id     (rsp_owner_id)
);

[sim/tb_round_robin_task_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_scheduler
// Self-checking bench for the round robin task scheduler: directed rows of
// commands, then a random command stream that keeps the table busy; each
// result is checked against typed-in values or a cycle-free table model.
// ----------------------------------------------------------------------------
module tb_round_robin_task_scheduler;

   localparam int NSLOT     = 16;
   localparam int CYC_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [15:0] req_task_id;
   logic [31:0] req_sleep_ms;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic [15:0] rsp_task_id_out;
   logic [2:0]  rsp_task_state;
   logic        rsp_id_valid;
   logic [4:0]  rsp_task_count;
   logic [31:0] rsp_slice_count;
   logic [1:0]  rsp_owner_action;
   logic [4:0]  rsp_owner_id;

   typedef struct packed {
      logic [15:0] tid;
      logic [2:0]  st;
      logic        vld;
      logic [4:0]  cnt;
      logic [31:0] slices;
      logic [1:0]  act;
      logic [4:0]  owner;
   } sched_result_type;

   // one row of the directed table; chk set means exp is typed in
   typedef struct {
      rrts_pkg::op_type op;
      logic [15:0]      tid;
      logic [31:0]      ms;
      logic [31:0]      now;
      bit               chk;
      sched_result_type exp;
   } cmd_row_type;

   round_robin_task_scheduler #(.NUM_SLOTS(NSLOT)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_task_id(req_task_id), .req_sleep_ms(req_sleep_ms),
      .req_now_ms(req_now_ms), .rsp_valid(rsp_valid),
      .rsp_task_id_out(rsp_task_id_out), .rsp_task_state(rsp_task_state),
      .rsp_id_valid(rsp_id_valid), .rsp_task_count(rsp_task_count),
      .rsp_slice_count(rsp_slice_count), .rsp_owner_action(rsp_owner_action),
      .rsp_owner_id(rsp_owner_id)
   );

   // shadow copy of the task table
   rrts_pkg::task_state_type tbl_state [NSLOT];
   logic [7:0]     tbl_gen   [NSLOT];
   logic [31:0]    tbl_slices[NSLOT];
   logic [31:0]    tbl_wake  [NSLOT];
   int             last_pick;
   logic [15:0]    cur_task;

   sched_result_type pending_results[$];
   int             fail_count;
   int             cycle_count;
   int             n_items;
   int             n_results;
   int             op_hits[8];

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int slot_of(logic [15:0] id);
      if (id[15:8] == 8'd0 || id[7:0] >= NSLOT) return -1;
      if (tbl_state[id[7:0]] == rrts_pkg::TS_FREE || tbl_gen[id[7:0]] != id[15:8])
         return -1;
      return int'(id[7:0]);
   endfunction

   task automatic table_reset();
      for (int i = 0; i < NSLOT; i++) begin
         tbl_state[i] = rrts_pkg::TS_FREE;
         tbl_gen[i] = 8'd1;
         tbl_slices[i] = '0;
         tbl_wake[i] = '0;
      end
      last_pick = NSLOT - 1;
      cur_task = '0;
   endtask

   // advance the shadow table by one command and return its result
   function automatic sched_result_type schedule_cmd(rrts_pkg::op_type op,
                                                     logic [15:0] id,
                                                     logic [31:0] ms,
                                                     logic [31:0] now);
      sched_result_type r;
      int s;
      int c;
      int k;
      logic [31:0] diff;
      r = '0;
      s = slot_of(id);
      r.vld = (s >= 0);
      case (op)
         rrts_pkg::OP_CREATE: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (tbl_state[i] == rrts_pkg::TS_FREE) begin
                  tbl_state[i] = rrts_pkg::TS_READY;
                  tbl_slices[i] = '0;
                  tbl_wake[i] = '0;
                  r.tid = {tbl_gen[i], 8'(i)};
                  break;
               end
            end
         end
         rrts_pkg::OP_NEXT: begin
            // wake sleepers whose deadline passed, wrap-safe
            for (int i = 0; i < NSLOT; i++) begin
               diff = now - tbl_wake[i];
               if (tbl_state[i] == rrts_pkg::TS_SLEEPING && !diff[31])
                  tbl_state[i] = rrts_pkg::TS_READY;
            end
            c = slot_of(cur_task);
            if (c >= 0 && tbl_state[c] == rrts_pkg::TS_RUNNING)
               tbl_state[c] = rrts_pkg::TS_READY;
            cur_task = '0;
            for (int i = 1; i <= NSLOT; i++) begin
               k = (last_pick + i) % NSLOT;
               if (tbl_state[k] == rrts_pkg::TS_READY) begin
                  tbl_state[k] = rrts_pkg::TS_RUNNING;
                  tbl_slices[k] += 1;
                  last_pick = k;
                  cur_task = {tbl_gen[k], 8'(k)};
                  r.tid = cur_task;
                  r.owner = 5'(k + 1);
                  break;
               end
            end
            r.act = rrts_pkg::ACT_SET;
         end
         rrts_pkg::OP_SLEEP: begin
            if (s >= 0 && tbl_state[s] != rrts_pkg::TS_DEAD) begin
               tbl_wake[s] = now + ms;
               tbl_state[s] = rrts_pkg::TS_SLEEPING;
            end
         end
         rrts_pkg::OP_BLOCK: begin
            if (s >= 0 && tbl_state[s] != rrts_pkg::TS_DEAD)
               tbl_state[s] = rrts_pkg::TS_BLOCKED;
         end
         rrts_pkg::OP_WAKE: begin
            if (s >= 0 && (tbl_state[s] inside {rrts_pkg::TS_BLOCKED,
                                                rrts_pkg::TS_SLEEPING}))
               tbl_state[s] = rrts_pkg::TS_READY;
         end
         rrts_pkg::OP_EXIT: begin
            if (s >= 0) begin
               tbl_state[s] = rrts_pkg::TS_DEAD;
               r.act = rrts_pkg::ACT_RELEASE;
               r.owner = 5'(s + 1);
               if (id == cur_task) cur_task = '0;
            end
         end
         rrts_pkg::OP_REAP: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (tbl_state[i] == rrts_pkg::TS_DEAD) begin
                  tbl_state[i] = rrts_pkg::TS_FREE;
                  tbl_gen[i] = tbl_gen[i] + 8'd1;
                  if (tbl_gen[i] == 8'd0) tbl_gen[i] = 8'd1;
                  r.cnt = r.cnt + 5'd1;
               end
            end
         end
         default: begin
            r.tid = cur_task;
            if (s >= 0) begin
               r.st = tbl_state[s];
               r.slices = tbl_slices[s];
            end
            for (int i = 0; i < NSLOT; i++)
               if (tbl_state[i] != rrts_pkg::TS_FREE) r.cnt = r.cnt + 5'd1;
         end
      endcase
      return r;
   endfunction

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      sched_result_type e;
      if (!reset && rsp_valid) begin
         n_results++;
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_task_id_out !== e.tid) begin
               $error("task_id_out exp %h got %h", e.tid, rsp_task_id_out);
               fail_count++;
            end
            if (rsp_task_state !== e.st) begin
               $error("task_state exp %0d got %0d", e.st, rsp_task_state);
               fail_count++;
            end
            if (rsp_id_valid !== e.vld) begin
               $error("id_valid exp %0d got %0d", e.vld, rsp_id_valid);
               fail_count++;
            end
            if (rsp_task_count !== e.cnt) begin
               $error("task_count exp %0d got %0d", e.cnt, rsp_task_count);
               fail_count++;
            end
            if (rsp_slice_count !== e.slices) begin
               $error("slice_count exp %0d got %0d", e.slices, rsp_slice_count);
               fail_count++;
            end
            if (rsp_owner_action !== e.act) begin
               $error("owner_action exp %0d got %0d", e.act, rsp_owner_action);
               fail_count++;
            end
            if (rsp_owner_id !== e.owner) begin
               $error("owner_id exp %0d got %0d", e.owner, rsp_owner_id);
               fail_count++;
            end
         end
      end
   end

   // issue one item after a random gap; chk uses the typed-in result
   // with no gap, start stays high straight into the next item
   task automatic issue_cmd(rrts_pkg::op_type op, logic [15:0] id, logic [31:0] ms,
                            logic [31:0] now, bit chk, sched_result_type exp);
      sched_result_type p;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_task_id <= id;
      req_sleep_ms <= ms;
      req_now_ms <= now;
      do @(posedge clock); while (busy);
      p = schedule_cmd(op, id, ms, now);
      pending_results.push_back(chk ? exp : p);
      n_items++;
      op_hits[op]++;
   endtask

   // id picker: mostly current-generation ids, sometimes stale or out of range
   function automatic logic [15:0] pick_id();
      int k;
      k = $urandom_range(0, 9);
      if (k < 7) begin
         int i;
         i = $urandom_range(0, NSLOT - 1);
         return {tbl_gen[i], 8'(i)};
      end else if (k == 7) return 16'($urandom);
      else if (k == 8) return cur_task;
      else return {8'($urandom_range(1, 255)), 8'($urandom_range(NSLOT, 255))};
   endfunction

   cmd_row_type dir_rows[$];
   logic [31:0] now_clock;

   initial begin
      sched_result_type z;
      rrts_pkg::op_type op;
      int w;
      z = '0;
      fail_count = 0; cycle_count = 0; n_items = 0; n_results = 0;
      for (int i = 0; i < 8; i++) op_hits[i] = 0;
      reset = 1'b1; start = 1'b0; req_op = rrts_pkg::OP_QUERY;
      req_task_id = '0; req_sleep_ms = '0; req_now_ms = '0;
      table_reset();

      // directed rows: empty table, extremes, error cases
      dir_rows.push_back('{rrts_pkg::OP_QUERY, 16'h0000, 32'd0, 32'd0, 1,
                           '{16'h0000, rrts_pkg::TS_FREE, 1'b0, 5'd0, 32'd0,
                             rrts_pkg::ACT_NONE, 5'd0}});
      dir_rows.push_back('{rrts_pkg::OP_NEXT, 16'h0000, 32'd0, 32'd0, 1,
                           '{16'h0000, rrts_pkg::TS_FREE, 1'b0, 5'd0, 32'd0,
                             rrts_pkg::ACT_SET, 5'd0}});
      dir_rows.push_back('{rrts_pkg::OP_EXIT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           1, z});
      dir_rows.push_back('{rrts_pkg::OP_CREATE, 16'h0000, 32'd0, 32'd0, 1,
                           '{16'h0100, rrts_pkg::TS_FREE, 1'b0, 5'd0, 32'd0,
                             rrts_pkg::ACT_NONE, 5'd0}});
      dir_rows.push_back('{rrts_pkg::OP_QUERY, 16'h0100, 32'd0, 32'd0, 1,
                           '{16'h0000, rrts_pkg::TS_READY, 1'b1, 5'd1, 32'd0,
                             rrts_pkg::ACT_NONE, 5'd0}});
      dir_rows.push_back('{rrts_pkg::OP_QUERY, 16'h0000, 32'd0, 32'd0, 1,
                           '{16'h0000, rrts_pkg::TS_FREE, 1'b0, 5'd1, 32'd0,
                             rrts_pkg::ACT_NONE, 5'd0}});
      dir_rows.push_back('{rrts_pkg::OP_NEXT, 16'h0000, 32'd0, 32'd0, 1,
                           '{16'h0100, rrts_pkg::TS_FREE, 1'b0, 5'd0, 32'd0,
                             rrts_pkg::ACT_SET, 5'd1}});
      for (int i = 0; i < NSLOT; i++)
         dir_rows.push_back('{rrts_pkg::OP_CREATE, 16'h0, 32'd0, 32'd0, 0, z});
      // table full, sleep across the time wrap, block, next, wake, exit, reap
      dir_rows.push_back('{rrts_pkg::OP_SLEEP, 16'h0101, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
                           0, z});
      dir_rows.push_back('{rrts_pkg::OP_BLOCK, 16'h0102, 32'd0, 32'd0, 0, z});
      dir_rows.push_back('{rrts_pkg::OP_NEXT, 16'h0000, 32'd0, 32'h7FFF_FFFF, 0, z});
      dir_rows.push_back('{rrts_pkg::OP_WAKE, 16'h0102, 32'd0, 32'd0, 0, z});
      dir_rows.push_back('{rrts_pkg::OP_EXIT, 16'h0100, 32'd0, 32'd0, 1,
                           '{16'h0000, rrts_pkg::TS_FREE, 1'b1, 5'd0, 32'd0,
                             rrts_pkg::ACT_RELEASE, 5'd1}});
      dir_rows.push_back('{rrts_pkg::OP_SLEEP, 16'h0100, 32'd5, 32'd0, 0, z});
      dir_rows.push_back('{rrts_pkg::OP_EXIT, 16'h010F, 32'd0, 32'd0, 0, z});
      dir_rows.push_back('{rrts_pkg::OP_REAP, 16'h0000, 32'd0, 32'd0, 1,
                           '{16'h0000, rrts_pkg::TS_FREE, 1'b0, 5'd2, 32'd0,
                             rrts_pkg::ACT_NONE, 5'd0}});
      dir_rows.push_back('{rrts_pkg::OP_QUERY, 16'h0100, 32'd0, 32'd0, 0, z});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         issue_cmd(dir_rows[i].op, dir_rows[i].tid, dir_rows[i].ms, dir_rows[i].now,
                   dir_rows[i].chk, dir_rows[i].exp);
      start <= 1'b0;

      // hold off until the result queue has drained
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);

      // random part: mostly lifecycle commands on live ids
      now_clock = 32'hFFFF_F000;
      for (int n = 0; n < 1800; n++) begin
         w = $urandom_range(0, 99);
         if (w < 15) op = rrts_pkg::OP_CREATE;
         else if (w < 45) op = rrts_pkg::OP_NEXT;
         else if (w < 55) op = rrts_pkg::OP_SLEEP;
         else if (w < 62) op = rrts_pkg::OP_BLOCK;
         else if (w < 72) op = rrts_pkg::OP_WAKE;
         else if (w < 80) op = rrts_pkg::OP_EXIT;
         else if (w < 86) op = rrts_pkg::OP_REAP;
         else op = rrts_pkg::OP_QUERY;
         now_clock += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 40);
         issue_cmd(op, pick_id(),
                   ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 100),
                   now_clock, 0, z);
      end
      start <= 1'b0;

      // drain, then let the block settle
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("ran %0d items, %0d results: create %0d next %0d sleep %0d block %0d",
               n_items, n_results, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
      $display("wake %0d exit %0d reap %0d query %0d, %0d mismatches",
               op_hits[4], op_hits[5], op_hits[6], op_hits[7], fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
